FILE: rtl/core/swrbm_pkg.sv
// Package for the SWR bar meter with band toggle.
// Holds the transfer payload types, band codes, register indexes and limit constants.
// No dependencies.
package swrbm_pkg;

    localparam int unsigned NUM_LIMITS  = 7;
    localparam int unsigned LIMIT_W     = 8;
    localparam int unsigned LIMITS_W    = NUM_LIMITS * LIMIT_W;
    localparam int unsigned LED_W       = NUM_LIMITS + 1;
    localparam int unsigned SAMPLE_W    = 8;

    localparam logic [LIMITS_W-1:0] LIMIT_RESET   = 56'h64_321E_140F_0D0C;
    localparam logic [11:0]         EQUAL_SCALED  = 12'd2550;
    localparam logic [3:0]          SWR_SCALE     = 4'd10;

    typedef enum logic [1:0] {
        BAND_OFF = 2'd0,
        BAND_2M  = 2'd1,
        BAND_80M = 2'd2
    } t_band;

    typedef enum logic {
        CFG_LIMITS_2M  = 1'b0,
        CFG_LIMITS_80M = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                reload;
        logic                button_2m_down;
        logic                button_80m_down;
        logic                sample_valid;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       band;
        logic [LED_W-1:0] led_pattern;
        logic             want_reflected;
        logic             level_updated;
    } t_out_item;

endpackage

FILE: rtl/core/swr_bar_meter_with_band_toggle_top.sv
// Top level of the SWR bar meter with band toggle.
// An accepted input is held in the input register; its result is offered from the output register.
// Throughput: one item per cycle while the output is not stalled; an input register feeds one
// combinational pass whose result lands in an output register, and both stages advance together.
// Reset (synchronous, active low) turns the carrier off, disarms both buttons,
// clears the LED bar and restores both limit registers to their defaults.
module swr_bar_meter_with_band_toggle_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  swrbm_pkg::t_in_item            i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output swrbm_pkg::t_out_item           o_out_item,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [swrbm_pkg::LIMITS_W-1:0] i_cfg_data
);
    import swrbm_pkg::*;

    logic [LIMITS_W-1:0] r_limits_2m;
    logic [LIMITS_W-1:0] r_limits_80m;
    logic                r_in_vld;
    t_in_item            r_in_item;
    logic                r_out_vld;
    t_out_item           r_out_item;
    logic                step;
    t_out_item           res;

    assign step        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || step;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    swrbm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_item       (r_in_item),
        .i_limits_2m  (r_limits_2m),
        .i_limits_80m (r_limits_80m),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits_2m  <= LIMIT_RESET;
            r_limits_80m <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LIMITS_2M:  r_limits_2m  <= i_cfg_data;
                CFG_LIMITS_80M: r_limits_80m <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (step) begin
            r_out_item <= res;
        end
    end

endmodule

FILE: rtl/core/swrbm_level.sv
// SWR level comparator: compares ten times (f+r)/(f-r) against seven limits.
// Produces a one-hot LED bar byte. Depends on swrbm_pkg.
module swrbm_level (
    input  logic [swrbm_pkg::SAMPLE_W-1:0] i_fwd,
    input  logic [swrbm_pkg::SAMPLE_W-1:0] i_refl,
    input  logic [swrbm_pkg::LIMITS_W-1:0] i_limits,
    output logic [swrbm_pkg::LED_W-1:0]    o_bar
);
    import swrbm_pkg::*;

    logic [SAMPLE_W:0]   sum;
    logic [SAMPLE_W-1:0] diff;
    logic [12:0]         scaled;
    logic                f_eq_r;
    logic                f_lt_r;
    logic [15:0]         prod [NUM_LIMITS];
    logic [NUM_LIMITS-1:0] below;

    always_comb begin
        sum    = {1'b0, i_fwd} + {1'b0, i_refl};
        diff   = i_fwd - i_refl;
        scaled = {4'b0, sum} * {9'b0, SWR_SCALE};
        f_eq_r = (i_fwd == i_refl);
        f_lt_r = (i_fwd < i_refl);
        for (int i = 0; i < NUM_LIMITS; i++) begin
            prod[i] = {8'b0, i_limits[i*LIMIT_W +: LIMIT_W]} * {8'b0, diff};
            if (f_eq_r) begin
                below[i] = EQUAL_SCALED < {4'b0, i_limits[i*LIMIT_W +: LIMIT_W]};
            end else if (f_lt_r) begin
                below[i] = 1'b1;
            end else begin
                below[i] = {3'b0, scaled} < prod[i];
            end
        end
        o_bar = {1'b1, {(LED_W-1){1'b0}}};
        for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
            if (below[i]) begin
                o_bar = LED_W'(1) << i;
            end
        end
    end

endmodule

FILE: rtl/core/swrbm_ctrl.sv
// Band, button re-arm and sample pairing state for the SWR bar meter.
// Computes one result per step. Depends on swrbm_pkg and swrbm_level.
module swrbm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  swrbm_pkg::t_in_item            i_item,
    input  logic [swrbm_pkg::LIMITS_W-1:0] i_limits_2m,
    input  logic [swrbm_pkg::LIMITS_W-1:0] i_limits_80m,
    output swrbm_pkg::t_out_item           o_res
);
    import swrbm_pkg::*;

    t_band                r_band,     n_band;
    logic                 r_armed_2m, n_armed_2m;
    logic                 r_armed_80m, n_armed_80m;
    logic                 r_pair,     n_pair;
    logic [LED_W-1:0]     r_bar,      n_bar;
    logic [SAMPLE_W-1:0]  r_fwd,      n_fwd;
    logic                 updated;
    logic [LIMITS_W-1:0]  limits_sel;
    logic [LED_W-1:0]     level_bar;

    swrbm_level u_level (
        .i_fwd    (r_fwd),
        .i_refl   (i_item.sample),
        .i_limits (limits_sel),
        .o_bar    (level_bar)
    );

    always_comb begin
        n_band      = r_band;
        n_armed_2m  = r_armed_2m;
        n_armed_80m = r_armed_80m;
        n_pair      = r_pair;
        n_bar       = r_bar;
        n_fwd       = r_fwd;
        updated     = 1'b0;

        if (i_item.reload) begin
            if (n_band != BAND_OFF) begin
                n_pair = 1'b0;
                n_bar  = '0;
            end
            n_band = BAND_OFF;
        end
        if (i_item.button_80m_down && n_band != BAND_80M && n_armed_80m) begin
            n_pair      = 1'b0;
            n_band      = BAND_80M;
            n_armed_80m = 1'b0;
        end
        if (i_item.button_2m_down && n_band != BAND_2M && n_armed_2m) begin
            n_pair     = 1'b0;
            n_band     = BAND_2M;
            n_armed_2m = 1'b0;
        end
        if (i_item.button_2m_down && n_band == BAND_2M && n_armed_2m) begin
            n_pair     = 1'b0;
            n_bar      = '0;
            n_band     = BAND_OFF;
            n_armed_2m = 1'b0;
        end
        if (i_item.button_80m_down && n_band == BAND_80M && n_armed_80m) begin
            n_pair      = 1'b0;
            n_bar       = '0;
            n_band      = BAND_OFF;
            n_armed_80m = 1'b0;
        end
        if (!i_item.button_2m_down) begin
            n_armed_2m = 1'b1;
        end
        if (!i_item.button_80m_down) begin
            n_armed_80m = 1'b1;
        end

        limits_sel = (n_band == BAND_2M) ? i_limits_2m : i_limits_80m;

        if ((n_band == BAND_2M || n_band == BAND_80M) && i_item.sample_valid) begin
            if (!n_pair) begin
                n_fwd  = i_item.sample;
                n_pair = 1'b1;
            end else begin
                n_bar   = level_bar;
                n_pair  = 1'b0;
                updated = 1'b1;
            end
        end

        o_res.band           = n_band;
        o_res.led_pattern    = n_bar;
        o_res.want_reflected = n_pair;
        o_res.level_updated  = updated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band      <= BAND_OFF;
            r_armed_2m  <= 1'b0;
            r_armed_80m <= 1'b0;
            r_pair      <= 1'b0;
            r_bar       <= '0;
        end else if (i_step) begin
            r_band      <= n_band;
            r_armed_2m  <= n_armed_2m;
            r_armed_80m <= n_armed_80m;
            r_pair      <= n_pair;
            r_bar       <= n_bar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_fwd <= n_fwd;
        end
    end

endmodule

FILE: test/swrbm_checker.sv
// Checker for the SWR bar meter: it watches the input, output and register write ports,
// predicts each reading from its own copy of the meter state and compares it field by field.
// Depends on swrbm_pkg for the transfer payload types, band codes and limit constants.
module swrbm_checker
    import swrbm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in_item            i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out_item           i_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [LIMITS_W-1:0] i_cfg_data,
    output int unsigned         o_pending,
    output int unsigned         o_errors
);

    localparam int unsigned MAX_PRINTED = 60;

    t_band               cur_band;
    bit                  arm_2m;
    bit                  arm_80m;
    bit                  expect_refl;
    logic [SAMPLE_W-1:0] fwd_sample;
    logic [LED_W-1:0]    bar_leds;
    logic [LIMITS_W-1:0] limits_2m;
    logic [LIMITS_W-1:0] limits_80m;
    t_out_item           expected_readings[$];
    int unsigned         fault_count = 0;

    task automatic report_fault(input string msg);
        if (fault_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        fault_count++;
    endtask

    function automatic void switch_band(input t_band nb);
        if (nb != cur_band) begin
            expect_refl = 1'b0;
            if (nb == BAND_OFF) begin
                bar_leds = '0;
            end
        end
        cur_band = nb;
    endfunction

    // Returns the first limit index whose limit exceeds ten times the SWR, or seven.
    function automatic int unsigned swr_level(input int unsigned f, input int unsigned r,
                                              input logic [LIMITS_W-1:0] lims);
        int unsigned lvl;
        int unsigned lim;
        bit          below;
        lvl = NUM_LIMITS;
        for (int k = NUM_LIMITS - 1; k >= 0; k--) begin
            lim = 32'(lims[k*LIMIT_W +: LIMIT_W]);
            if (f == r) begin
                below = EQUAL_SCALED < lim;
            end else if (f < r) begin
                below = 1'b1;
            end else begin
                below = SWR_SCALE * (f + r) < lim * (f - r);
            end
            if (below) begin
                lvl = k;
            end
        end
        return lvl;
    endfunction

    function automatic t_out_item predict_meter_step(input t_in_item it);
        t_out_item           res;
        logic                updated;
        logic [LIMITS_W-1:0] lims;
        updated = 1'b0;
        if (it.reload) begin
            switch_band(BAND_OFF);
        end
        if (it.button_80m_down && cur_band != BAND_80M && arm_80m) begin
            switch_band(BAND_80M);
            arm_80m = 1'b0;
        end
        if (it.button_2m_down && cur_band != BAND_2M && arm_2m) begin
            switch_band(BAND_2M);
            arm_2m = 1'b0;
        end
        if (it.button_2m_down && cur_band == BAND_2M && arm_2m) begin
            switch_band(BAND_OFF);
            arm_2m = 1'b0;
        end
        if (it.button_80m_down && cur_band == BAND_80M && arm_80m) begin
            switch_band(BAND_OFF);
            arm_80m = 1'b0;
        end
        if (!it.button_2m_down) begin
            arm_2m = 1'b1;
        end
        if (!it.button_80m_down) begin
            arm_80m = 1'b1;
        end
        if (cur_band != BAND_OFF && it.sample_valid) begin
            if (!expect_refl) begin
                fwd_sample  = it.sample;
                expect_refl = 1'b1;
            end else begin
                lims        = (cur_band == BAND_2M) ? limits_2m : limits_80m;
                bar_leds    = LED_W'(1) << swr_level(32'(fwd_sample), 32'(it.sample), lims);
                expect_refl = 1'b0;
                updated     = 1'b1;
            end
        end
        res.band           = cur_band;
        res.led_pattern    = bar_leds;
        res.want_reflected = expect_refl;
        res.level_updated  = updated;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            cur_band    = BAND_OFF;
            arm_2m      = 1'b0;
            arm_80m     = 1'b0;
            expect_refl = 1'b0;
            fwd_sample  = '0;
            bar_leds    = '0;
            limits_2m   = LIMIT_RESET;
            limits_80m  = LIMIT_RESET;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LIMITS_2M) begin
                    limits_2m = i_cfg_data;
                end else begin
                    limits_80m = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    report_fault($sformatf("unexpected reading %p", i_out_item));
                end else begin
                    exp_item = expected_readings.pop_front();
                    if (i_out_item.band !== exp_item.band) begin
                        report_fault($sformatf("band got %0d, expected %0d",
                                               i_out_item.band, exp_item.band));
                    end
                    if (i_out_item.led_pattern !== exp_item.led_pattern) begin
                        report_fault($sformatf("led_pattern got %b, expected %b",
                                               i_out_item.led_pattern, exp_item.led_pattern));
                    end
                    if (i_out_item.want_reflected !== exp_item.want_reflected) begin
                        report_fault($sformatf("want_reflected got %b, expected %b",
                                               i_out_item.want_reflected,
                                               exp_item.want_reflected));
                    end
                    if (i_out_item.level_updated !== exp_item.level_updated) begin
                        report_fault($sformatf("level_updated got %b, expected %b",
                                               i_out_item.level_updated,
                                               exp_item.level_updated));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_readings.push_back(predict_meter_step(i_in_item));
            end
        end
        o_pending <= expected_readings.size();
        o_errors  <= fault_count;
    end

endmodule

FILE: test/tb_swr_bar_meter_with_band_toggle_top.sv
// Testbench top for the SWR bar meter with band toggle: it drives directed and random loop
// passes, limit register writes and output stalls, and gives the verdict.
// Depends on swrbm_pkg, swr_bar_meter_with_band_toggle_top and swrbm_checker.
module tb_swr_bar_meter_with_band_toggle_top;
    import swrbm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned BATCH_ITEMS = 245;
    localparam int unsigned NUM_PHASES  = 7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in_item            in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_item           out_item;
    logic                cfg_we = 1'b0;
    logic                cfg_idx = 1'b0;
    logic [LIMITS_W-1:0] cfg_data = '0;
    int unsigned         pending;
    int unsigned         errors;

    bit                  gaps_on = 1'b1;
    logic [SAMPLE_W-1:0] prev_sample = '0;
    int unsigned         stall_left = 0;
    int unsigned         rx_mode_left = 0;
    bit                  rx_steady = 1'b0;
    int unsigned         cycle_count = 0;

    always #1 i_clk = ~i_clk;

    swr_bar_meter_with_band_toggle_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    swrbm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item mk_item(input bit rl, input bit b2, input bit b80,
                                         input bit sv, input logic [SAMPLE_W-1:0] s);
        t_in_item it;
        it.reload          = rl;
        it.button_2m_down  = b2;
        it.button_80m_down = b80;
        it.sample_valid    = sv;
        it.sample          = s;
        return it;
    endfunction

    // Mostly released buttons and valid samples, so that pairs complete between band changes.
    function automatic t_in_item random_item();
        t_in_item            it;
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = prev_sample;
            1: s = '0;
            2: s = '1;
            3, 4: s = SAMPLE_W'($urandom_range(0, prev_sample));
            5: s = SAMPLE_W'($urandom_range(prev_sample, 255));
            default: s = SAMPLE_W'($urandom_range(0, 255));
        endcase
        it = mk_item($urandom_range(0, 99) < 2, $urandom_range(0, 99) < 5,
                     $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 75, s);
        if (it.sample_valid) begin
            prev_sample = s;
        end
        return it;
    endfunction

    function automatic logic [LIMITS_W-1:0] rising_limits();
        logic [LIMITS_W-1:0] v;
        int unsigned         acc;
        acc = $urandom_range(10, 20);
        for (int k = 0; k < NUM_LIMITS; k++) begin
            v[k*LIMIT_W +: LIMIT_W] = (acc > 255) ? 8'd255 : LIMIT_W'(acc);
            acc += $urandom_range(1, 40);
        end
        return v;
    endfunction

    task automatic send(input t_in_item item);
        int unsigned gap;
        gap = gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limits(input t_cfg_idx idx, input logic [LIMITS_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_batch(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                gaps_on = $urandom_range(0, 3) != 0;
            end
            if (k == n / 2) begin
                drain();
            end
            send(random_item());
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode_left <= $urandom_range(50, 300);
            rx_steady    <= $urandom_range(0, 3) == 0;
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready  <= 1'b1;
            stall_left <= rx_steady ? 0 : pick_gap();
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Buttons start disarmed, so the first press is ignored until a release.
        send(mk_item(0, 1, 0, 0, 8'h00));
        send(mk_item(0, 0, 0, 1, 8'hFF));
        send(mk_item(0, 1, 0, 0, 8'h00));
        send(mk_item(0, 1, 0, 1, 8'hFF));
        send(mk_item(0, 0, 0, 1, 8'h00));
        send(mk_item(0, 0, 0, 1, 8'h00));
        send(mk_item(0, 0, 0, 1, 8'h00));
        send(mk_item(0, 0, 0, 1, 8'h0A));
        send(mk_item(0, 0, 0, 1, 8'hC8));
        send(mk_item(0, 0, 0, 1, 8'h64));
        send(mk_item(0, 0, 0, 1, 8'h32));
        send(mk_item(0, 0, 0, 1, 8'h80));
        send(mk_item(0, 1, 1, 1, 8'h09));
        send(mk_item(0, 0, 0, 0, 8'h00));
        send(mk_item(0, 1, 0, 0, 8'h00));
        send(mk_item(0, 0, 0, 0, 8'h00));
        send(mk_item(0, 0, 1, 1, 8'hC8));
        send(mk_item(0, 0, 0, 1, 8'h64));
        send(mk_item(1, 1, 1, 1, 8'h55));
        send(mk_item(0, 0, 0, 1, 8'h2A));
        send(mk_item(1, 0, 0, 1, 8'hAA));
        send(mk_item(0, 0, 1, 0, 8'h00));
        send(mk_item(0, 0, 0, 0, 8'h00));
        send(mk_item(0, 0, 1, 1, 8'h01));

        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: begin
                        write_limits(CFG_LIMITS_2M, '0);
                        write_limits(CFG_LIMITS_80M, '1);
                    end
                    2: begin
                        write_limits(CFG_LIMITS_2M, '1);
                        write_limits(CFG_LIMITS_80M, '0);
                    end
                    4: begin
                        write_limits(CFG_LIMITS_2M, LIMITS_W'({$urandom(), $urandom()}));
                        write_limits(CFG_LIMITS_80M, LIMITS_W'({$urandom(), $urandom()}));
                    end
                    6: begin
                        write_limits(CFG_LIMITS_2M, LIMIT_RESET);
                        write_limits(CFG_LIMITS_80M, rising_limits());
                    end
                    default: begin
                        write_limits(CFG_LIMITS_2M, rising_limits());
                        write_limits(CFG_LIMITS_80M, rising_limits());
                    end
                endcase
            end
            run_batch(BATCH_ITEMS);
        end

        drain();
        repeat (6) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
